>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define PPID_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ppid assertion failed");

// checked on every edge, reset included
`define PPID_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ppid assertion failed");

`endif

>>> sv/ppid_pkg.sv
`default_nettype none

package ppid_pkg;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_INTEG_GAIN    = 3'd1,
    CFG_DERIV_GAIN    = 3'd2,
    CFG_INTEGRAL_BAND = 3'd3,
    CFG_DERIV_SOURCE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic signed [31:0] deriv_gain;
    logic        [30:0] integral_band;
    logic               deriv_source;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic signed [31:0] measured_rate;
    logic               link_online;
  } smp_t;

  typedef struct packed {
    logic signed [31:0] err;
    logic signed [31:0] d_src;
    logic               cleared;
  } err_t;

  typedef struct packed {
    logic signed [63:0] prod_p;
    logic signed [63:0] prod_i;
    logic signed [63:0] prod_d;
    logic               cleared;
  } prod_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               integ_cleared;
  } res_t;

endpackage

`default_nettype wire

>>> sv/ppid_sample_if.sv
`default_nettype none

interface ppid_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;
  logic signed [31:0] measured_rate;
  logic               link_online;

  modport source (
    output valid, setpoint, measured, measured_rate, link_online,
    input  ready
  );

  modport sink (
    input  valid, setpoint, measured, measured_rate, link_online,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/ppid_result_if.sv
`default_nettype none

interface ppid_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               integ_cleared;

  modport source (
    output valid, drive, integ_cleared,
    input  ready
  );

  modport sink (
    input  valid, drive, integ_cleared,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/ppid_front.sv
`default_nettype none
`include "assert_macros.svh"

module ppid_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ppid_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ppid_pkg::smp_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ppid_pkg::err_t     out_data_o
);
  import ppid_pkg::*;

  typedef struct packed {
    logic signed [31:0] err;
    logic signed [31:0] rate;
    logic               online;
  } stage1_t;

  logic    v0_q, v1_q, v2_q;
  smp_t    r0_q;
  stage1_t r1_q, r1_d;
  err_t    r2_q, r2_d;
  logic signed [31:0] prev_err_q;

  logic en0, en1, en2, fire2;
  logic signed [32:0] err_wide;
  logic signed [32:0] diff_wide;
  logic signed [31:0] diff_sat;
  logic        [31:0] err_mag;

  assign en2   = !v2_q || out_ready_i;
  assign en1   = !v1_q || en2;
  assign en0   = !v0_q || en1;
  assign fire2 = v1_q && en2;

  assign in_ready_o  = en0;
  assign out_valid_o = v2_q;
  assign out_data_o  = r2_q;

  // error, saturated to 32 bits
  always_comb begin
    err_wide = {r0_q.setpoint[31], r0_q.setpoint} - {r0_q.measured[31], r0_q.measured};
    r1_d.rate   = r0_q.measured_rate;
    r1_d.online = r0_q.link_online;
    if (err_wide[32] != err_wide[31]) begin
      r1_d.err = err_wide[32] ? S32_MIN : S32_MAX;
    end else begin
      r1_d.err = err_wide[31:0];
    end
  end

  // derivative source and integral separation
  always_comb begin
    diff_wide = {r1_q.err[31], r1_q.err} - {prev_err_q[31], prev_err_q};
    if (diff_wide[32] != diff_wide[31]) begin
      diff_sat = diff_wide[32] ? S32_MIN : S32_MAX;
    end else begin
      diff_sat = diff_wide[31:0];
    end
    err_mag      = r1_q.err[31] ? (32'd0 - r1_q.err) : r1_q.err;
    r2_d.err     = r1_q.err;
    r2_d.d_src   = cfg_i.deriv_source ? r1_q.rate : diff_sat;
    r2_d.cleared = (err_mag > {1'b0, cfg_i.integral_band}) || !r1_q.online;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q       <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      prev_err_q <= '0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (fire2) begin
        prev_err_q <= r1_q.err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      r0_q <= in_data_i;
    end
    if (en1 && v0_q) begin
      r1_q <= r1_d;
    end
    if (fire2) begin
      r2_q <= r2_d;
    end
  end

  `PPID_ASSERT(a_prev_err_tracks, fire2 |=> prev_err_q == $past(r1_q.err))
  `PPID_ASSERT(a_offline_clears, fire2 && !r1_q.online |=> r2_q.cleared)

endmodule

`default_nettype wire

>>> sv/ppid_mul.sv
`default_nettype none

module ppid_mul (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ppid_pkg::cfg_t  cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ppid_pkg::err_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ppid_pkg::prod_t     out_data_o
);
  import ppid_pkg::*;

  logic  v_q, en;
  prod_t r_q, r_d;

  assign en          = !v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q;
  assign out_data_o  = r_q;

  // three independent 32x32 products
  always_comb begin
    r_d.prod_p  = $signed(in_data_i.err)   * $signed(cfg_i.prop_gain);
    r_d.prod_i  = $signed(in_data_i.err)   * $signed(cfg_i.integ_gain);
    r_d.prod_d  = $signed(in_data_i.d_src) * $signed(cfg_i.deriv_gain);
    r_d.cleared = in_data_i.cleared;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      r_q <= r_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/ppid_acc.sv
`default_nettype none
`include "assert_macros.svh"

module ppid_acc (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ppid_pkg::prod_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ppid_pkg::res_t      out_data_o
);
  import ppid_pkg::*;

  typedef struct packed {
    logic signed [47:0] p_term;
    logic signed [47:0] d_term;
    logic               cleared;
  } term_t;

  logic  vd_q, ve_q;
  logic  en_d, en_e, fire_d;
  term_t d_q, d_d;
  res_t  e_q, e_d;
  logic signed [47:0] integ_q, integ_d;

  logic signed [63:0] neg_d;
  logic signed [47:0] i_term;
  logic signed [48:0] integ_sum;
  logic signed [49:0] total;

  assign en_e   = !ve_q || out_ready_i;
  assign en_d   = !vd_q || en_e;
  assign fire_d = in_valid_i && en_d;

  assign in_ready_o  = en_d;
  assign out_valid_o = ve_q;
  assign out_data_o  = e_q;

  // scale back to Q16.16 by floor shift, integrator with saturation and clear
  always_comb begin
    neg_d       = 64'sd0 - in_data_i.prod_d;
    i_term      = in_data_i.prod_i[63:16];
    d_d.p_term  = in_data_i.prod_p[63:16];
    d_d.d_term  = neg_d[63:16];
    d_d.cleared = in_data_i.cleared;
    integ_sum   = {integ_q[47], integ_q} + {i_term[47], i_term};
    if (in_data_i.cleared) begin
      integ_d = '0;
    end else if (integ_sum[48] != integ_sum[47]) begin
      integ_d = integ_sum[48] ? S48_MIN : S48_MAX;
    end else begin
      integ_d = integ_sum[47:0];
    end
  end

  // output sum saturated to 32 bits
  always_comb begin
    total = {{2{d_q.p_term[47]}}, d_q.p_term}
          + {{2{integ_q[47]}}, integ_q}
          + {{2{d_q.d_term[47]}}, d_q.d_term};
    e_d.integ_cleared = d_q.cleared;
    if (!(&total[49:31]) && (|total[49:31])) begin
      e_d.drive = total[49] ? S32_MIN : S32_MAX;
    end else begin
      e_d.drive = total[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q    <= 1'b0;
      ve_q    <= 1'b0;
      integ_q <= '0;
    end else begin
      if (en_d) begin
        vd_q <= in_valid_i;
      end
      if (en_e) begin
        ve_q <= vd_q;
      end
      if (fire_d) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_d) begin
      d_q <= d_d;
    end
    if (en_e && vd_q) begin
      e_q <= e_d;
    end
  end

  `PPID_ASSERT(a_clear_zeroes_integ, fire_d && in_data_i.cleared |=> integ_q == 48'sd0)
  `PPID_ASSERT(a_integ_holds_idle, !fire_d |=> $stable(integ_q))
  `PPID_ASSERT_ALWAYS(a_reset_integ_zero, !rst_ni |-> integ_q == 48'sd0)

endmodule

`default_nettype wire

>>> sv/positional_pid_integral_separation.sv
// channel   dir  handshake                      beat
// sample_i  in   valid / ready                  setpoint, measured, measured_rate, link_online
// result_o  out  valid / ready                  drive, integ_cleared
// cfg       in   cfg_we_i (no ready)            cfg_idx_i, cfg_wdata_i
//
// one beat accepted per cycle while no full stage is held by a stalled result_o
// six register stages: input, error, separation, multiply, integrator, output sum
// the integrator add in the fifth stage is the only loop and closes through the integrator register alone
// reset is asynchronous; gains, band, mode, integrator and previous error clear to 0
// a stalled result_o holds only the stages that are full; bubbles still drain
`default_nettype none

module positional_pid_integral_separation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ppid_sample_if.sink      sample_i,
  ppid_result_if.source    result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import ppid_pkg::*;

  cfg_t  cfg_q;
  smp_t  smp;
  err_t  err_data;
  prod_t prod_data;
  res_t  res_data;
  logic  err_valid, err_ready;
  logic  prod_valid, prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_wdata_i;
        CFG_INTEG_GAIN:    cfg_q.integ_gain    <= cfg_wdata_i;
        CFG_DERIV_GAIN:    cfg_q.deriv_gain    <= cfg_wdata_i;
        CFG_INTEGRAL_BAND: cfg_q.integral_band <= cfg_wdata_i[30:0];
        CFG_DERIV_SOURCE:  cfg_q.deriv_source  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign smp.setpoint      = sample_i.setpoint;
  assign smp.measured      = sample_i.measured;
  assign smp.measured_rate = sample_i.measured_rate;
  assign smp.link_online   = sample_i.link_online;

  ppid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .in_data_i   (smp),
    .out_valid_o (err_valid),
    .out_ready_i (err_ready),
    .out_data_o  (err_data)
  );

  ppid_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (err_valid),
    .in_ready_o  (err_ready),
    .in_data_i   (err_data),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_data_o  (prod_data)
  );

  ppid_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_ready_o  (prod_ready),
    .in_data_i   (prod_data),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (res_data)
  );

  assign result_o.drive         = res_data.drive;
  assign result_o.integ_cleared = res_data.integ_cleared;

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ppid_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 7;
  localparam int PIPE_LATENCY = 5;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_BEATS  = 50;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIR_ROWS     = 18;

  localparam logic [2:0]         CFG_SPARE_LO = 3'd5;
  localparam logic [2:0]         CFG_SPARE_HI = 3'd7;
  localparam logic signed [31:0] Q_ONE        = 32'sh0001_0000;

  typedef struct packed {
    logic [1:0]         setting;
    logic signed [31:0] sp;
    logic signed [31:0] fb;
    logic signed [31:0] rate;
    logic               online;
    logic               typed;
    logic signed [31:0] drive;
    logic               clr;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  ppid_sample_if smp_if ();
  ppid_result_if res_if ();

  positional_pid_integral_separation u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (smp_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state and its copy of the registers
  longint   kp = 0, ki = 0, kd = 0, band = 0;
  logic     rate_mode = 1'b0;
  longint   integ_acc = 0, last_err = 0;

  res_t     drive_q [$];
  int       n_err = 0;
  int       cycle_cnt = 0;
  int       burst_left = 0;
  int       stall_cnt = 0;
  int       stall_mode = 0;
  logic     typed_beat = 1'b0;
  res_t     typed_res;

  dir_row_t dir_rows [0:DIR_ROWS-1];
  cfg_t     dir_cfg [0:2];

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    return clip(v, longint'(S32_MIN), longint'(S32_MAX));
  endfunction

  function automatic res_t predict_drive(logic signed [31:0] sp, logic signed [31:0] fb,
                                         logic signed [31:0] rate, logic online);
    longint err, p_term, d_src, d_term, sum;
    res_t   r;
    err = sat32(longint'(sp) - longint'(fb));
    p_term = (err * kp) >>> 16;
    integ_acc = clip(integ_acc + ((err * ki) >>> 16), longint'(S48_MIN), longint'(S48_MAX));
    r.integ_cleared = (err > band) || (err < -band) || !online;
    if (r.integ_cleared) integ_acc = 0;
    d_src = rate_mode ? longint'(rate) : sat32(err - last_err);
    d_term = (-(kd * d_src)) >>> 16;
    last_err = err;
    sum = sat32(p_term + integ_acc + d_term);
    r.drive = 32'(sum);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_err++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:     kp = longint'($signed(cfg_wdata_i));
        CFG_INTEG_GAIN:    ki = longint'($signed(cfg_wdata_i));
        CFG_DERIV_GAIN:    kd = longint'($signed(cfg_wdata_i));
        CFG_INTEGRAL_BAND: band = longint'(cfg_wdata_i[30:0]);
        CFG_DERIV_SOURCE:  rate_mode = cfg_wdata_i[0];
        default: ;
      endcase
    end
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      want = predict_drive(smp_if.setpoint, smp_if.measured, smp_if.measured_rate,
                           smp_if.link_online);
      drive_q.push_back(typed_beat ? typed_res : want);
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (drive_q.size() == 0) begin
        report_mismatch("result beat with no sample pending", res_if.drive, 32'h0);
      end else begin
        want = drive_q.pop_front();
        if (res_if.drive !== want.drive)
          report_mismatch("drive", res_if.drive, want.drive);
        if (res_if.integ_cleared !== want.integ_cleared)
          report_mismatch("integ_cleared", 32'(res_if.integ_cleared),
                          32'(want.integ_cleared));
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 48 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      2: res_if.ready <= $urandom_range(0, 1);
      default: res_if.ready <= ((stall_cnt % 16) >= 11);
    endcase
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic apply_cfg(cfg_t c, logic [31:0] junk, logic spare);
    write_reg(CFG_PROP_GAIN, c.prop_gain);
    write_reg(CFG_INTEG_GAIN, c.integ_gain);
    write_reg(CFG_DERIV_GAIN, c.deriv_gain);
    write_reg(CFG_INTEGRAL_BAND, {junk[31], c.integral_band});
    write_reg(CFG_DERIV_SOURCE, {junk[30:0], c.deriv_source});
    if (spare) write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic quiesce();
    @(negedge clk_i) smp_if.valid <= 1'b0;
    wait_drained();
  endtask

  task automatic send_sample(logic signed [31:0] sp, logic signed [31:0] fb,
                             logic signed [31:0] rate, logic online,
                             logic typed, res_t want);
    @(negedge clk_i);
    typed_beat = typed;
    typed_res  = want;
    smp_if.valid         <= 1'b1;
    smp_if.setpoint      <= sp;
    smp_if.measured      <= fb;
    smp_if.measured_rate <= rate;
    smp_if.link_online   <= online;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  // bursts of back-to-back beats with gaps, now and then a full drain
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 40);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if ($urandom_range(0, 15) == 0) begin
      quiesce();
    end else if (gap > 0) begin
      @(negedge clk_i) smp_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 3))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return pick_edge();
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.prop_gain  = rand_gain();
    c.integ_gain = rand_gain();
    c.deriv_gain = rand_gain();
    case ($urandom_range(0, 3))
      0: c.integral_band = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
      1: c.integral_band = 31'($urandom);
      default: c.integral_band = 31'($urandom_range(0, 32'h4_0000));
    endcase
    c.deriv_source = $urandom_range(0, 1);
    return c;
  endfunction

  task automatic send_random();
    logic signed [31:0] sp, fb, rate;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        sp = $urandom;
        fb = sp + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      end
      5, 6: begin
        sp = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
        fb = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      end
      7: begin
        sp = pick_edge();
        fb = pick_edge();
      end
      default: begin
        sp = $urandom;
        fb = $urandom;
      end
    endcase
    rate = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 32'h7_FFFF) - 32'h4_0000);
    send_sample(sp, fb, rate, $urandom_range(0, 7) != 0, 1'b0, '0);
  endtask

  initial begin
    logic [1:0] cur_set;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    smp_if.valid  = 1'b0;
    smp_if.setpoint      = '0;
    smp_if.measured      = '0;
    smp_if.measured_rate = '0;
    smp_if.link_online   = 1'b0;
    res_if.ready  = 1'b0;

    dir_cfg = '{
      '0,
      '{Q_ONE, S32_MAX, S32_MIN, 31'h7FFF_FFFF, 1'b0},
      '{S32_MIN, 32'sh0000_8000, Q_ONE, 31'h0001_0000, 1'b1}
    };
    dir_rows = '{
      '{2'd0, 32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b1, 32'sh0, 1'b0},
      '{2'd0, S32_MAX, S32_MIN, S32_MAX, 1'b1, 1'b1, 32'sh0, 1'b1},
      '{2'd0, S32_MIN, S32_MAX, S32_MIN, 1'b0, 1'b1, 32'sh0, 1'b1},
      '{2'd0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b1, 32'sh0, 1'b1},
      '{2'd1, S32_MAX, S32_MIN, 32'sh1234, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, S32_MAX, S32_MIN, 32'sh1234, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, S32_MAX, S32_MIN, 32'sh1234, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, S32_MAX, S32_MIN, 32'sh1234, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, S32_MIN, S32_MAX, 32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, 32'sh8000_0001, 32'sh0, 32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, 32'sh8000_0001, 32'sh0, 32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, 32'sh8000_0001, 32'sh0, 32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd1, 32'sh8000_0001, 32'sh0, 32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd2, Q_ONE, 32'sh0, S32_MAX, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd2, 32'sh0, Q_ONE, S32_MIN, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd2, 32'sh0001_0001, 32'sh0, 32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd2, 32'sh0, 32'sh0001_0001, 32'sh0, 1'b1, 1'b0, 32'sh0, 1'b0},
      '{2'd2, 32'sh0, 32'sh0, 32'sh0000_FFFF, 1'b0, 1'b0, 32'sh0, 1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // writes to spare indexes must leave the zero gains alone
    for (int idx = CFG_SPARE_LO; idx <= CFG_SPARE_HI; idx++) write_reg(3'(idx), 32'hFFFF_FFFF);
    @(negedge clk_i) cfg_we_i <= 1'b0;

    cur_set = 2'd0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].setting != cur_set) begin
        cur_set = dir_rows[i].setting;
        quiesce();
        apply_cfg(dir_cfg[cur_set], 32'h0, 1'b0);
      end
      send_sample(dir_rows[i].sp, dir_rows[i].fb, dir_rows[i].rate, dir_rows[i].online,
                  dir_rows[i].typed, '{dir_rows[i].drive, dir_rows[i].clr});
      pace();
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiesce();
      apply_cfg(rand_cfg(), $urandom, $urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_random();
        pace();
      end
    end

    quiesce();
    repeat (PIPE_LATENCY * 4) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
